/* hdl/matrix_matrix_multiply_defines.svh */
// Assertion macros for the matrix multiply block.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef MATRIX_MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MATRIX_MULTIPLY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition must hold in the same cycle as the trigger
`define MMM_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);
// Condition must hold in the cycle after the trigger
`define MMM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define MMM_ASSERT_SAME(lbl, trig, cond, msg)
`define MMM_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

/* hdl/mmm_pkg.sv */
// Shared constants, codes, types and helpers of the matrix multiply block.
// No dependencies.
package mmm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DIM_W     = 4;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = 35;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_LOAD_A  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_B  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             we_a;
        logic             we_b;
        logic             rd_en;
        logic [IDX_W-1:0] rd_i;
        logic [IDX_W-1:0] rd_j;
        logic [IDX_W-1:0] rd_k;
        logic             first;
        logic             last;
        logic             load_out;
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic             out_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_status;

    // Highest index used for a dimension register: 0 acts as 1, above MAX_DIM clamps
    function automatic logic [IDX_W-1:0] eff_last(input logic [DIM_W-1:0] r);
        logic [IDX_W-1:0] res;
        if (r == '0) begin
            res = '0;
        end else if (int'(r) > MAX_DIM) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(r - 1'b1);
        end
        return res;
    endfunction

endpackage

/* hdl/mmm_if.sv */
// Valid/ready channel interfaces of the matrix multiply block.
// Depends on mmm_pkg.
interface mmm_req_if;
    logic                                valid;
    logic                                ready;
    logic [mmm_pkg::FUNC_W-1:0]          func;
    logic [mmm_pkg::IDX_W-1:0]           row;
    logic [mmm_pkg::IDX_W-1:0]           col;
    logic signed [mmm_pkg::VAL_W-1:0]    value;

    modport source (output valid, func, row, col, value, input ready);
    modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mmm_res_if;
    logic                                valid;
    logic                                ready;
    logic [mmm_pkg::IDX_W-1:0]           out_row;
    logic [mmm_pkg::IDX_W-1:0]           out_col;
    logic signed [mmm_pkg::SUM_W-1:0]    sum;
    logic                                last;

    modport source (output valid, out_row, out_col, sum, last, input ready);
    modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

/* hdl/mmm_datapath.sv */
// Datapath: A and B element memories, multiply-accumulate pipeline, output register.
// Depends on mmm_pkg; driven by mmm_ctrl through t_cmd / t_status.
module mmm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmm_pkg::t_cmd                       i_cmd,
    output mmm_pkg::t_status                    o_status,
    input  logic [mmm_pkg::IDX_W-1:0]           i_wr_row,
    input  logic [mmm_pkg::IDX_W-1:0]           i_wr_col,
    input  logic signed [mmm_pkg::VAL_W-1:0]    i_wr_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mmm_pkg::IDX_W-1:0]           o_out_row,
    output logic [mmm_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [mmm_pkg::SUM_W-1:0]    o_out_sum,
    output logic                                o_out_last
);

    logic signed [mmm_pkg::VAL_W-1:0]  a_mem [mmm_pkg::DEPTH];
    logic signed [mmm_pkg::VAL_W-1:0]  b_mem [mmm_pkg::DEPTH];

    logic [mmm_pkg::ADDR_W-1:0]        wr_addr;
    logic [mmm_pkg::ADDR_W-1:0]        rd_addr_a;
    logic [mmm_pkg::ADDR_W-1:0]        rd_addr_b;

    logic signed [mmm_pkg::VAL_W-1:0]  r_a_q;
    logic signed [mmm_pkg::VAL_W-1:0]  r_b_q;
    logic                              r_v1, r_first1, r_last1;
    logic signed [mmm_pkg::PROD_W-1:0] r_prod;
    logic                              r_v2, r_first2, r_last2;
    logic signed [mmm_pkg::SUM_W-1:0]  r_acc;
    logic                              r_done;
    logic signed [mmm_pkg::SUM_W-1:0]  prod_ext;

    logic                              r_out_valid;
    logic [mmm_pkg::IDX_W-1:0]         r_out_row;
    logic [mmm_pkg::IDX_W-1:0]         r_out_col;
    logic signed [mmm_pkg::SUM_W-1:0]  r_out_sum;
    logic                              r_out_last;

    // Row-major addressing: row * MAX_DIM + col
    assign wr_addr   = {i_wr_row, i_wr_col};
    assign rd_addr_a = {i_cmd.rd_i, i_cmd.rd_k};
    assign rd_addr_b = {i_cmd.rd_k, i_cmd.rd_j};

    // Element memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.we_a) begin
            a_mem[wr_addr] <= i_wr_value;
        end
        r_a_q <= a_mem[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_b) begin
            b_mem[wr_addr] <= i_wr_value;
        end
        r_b_q <= b_mem[rd_addr_b];
    end

    // Stage flags follow the read data down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_cmd.rd_en;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_last2;
        end
    end

    // Product and accumulate (Q8.8 x Q8.8 gives exact Q16.16)
    assign prod_ext = mmm_pkg::SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_prod   <= r_a_q * r_b_q;
        if (r_v2) begin
            r_acc <= r_first2 ? prod_ext : r_acc + prod_ext;
        end
    end

    // Output register; frees up when the receiver takes the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_row  <= i_cmd.out_row;
            r_out_col  <= i_cmd.out_col;
            r_out_sum  <= r_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_status.acc_done = r_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_sum   = r_out_sum;
    assign o_out_last  = r_out_last;

endmodule

/* hdl/mmm_ctrl.sv */
// Controller: configuration registers, request handshake and the i/j/k loop sequencer.
// Depends on mmm_pkg; drives mmm_datapath through t_cmd / t_status.
module mmm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mmm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmm_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_req_valid,
    input  logic [mmm_pkg::FUNC_W-1:0]        i_req_func,
    output logic                              o_req_ready,
    input  mmm_pkg::t_status                  i_status,
    output mmm_pkg::t_cmd                     o_cmd
);

    mmm_pkg::t_state               r_state, n_state;
    logic [mmm_pkg::DIM_W-1:0]     r_rows, r_inner, r_cols;
    logic [mmm_pkg::IDX_W-1:0]     r_i, r_j, r_k;
    logic [mmm_pkg::IDX_W-1:0]     n_i, n_j, n_k;
    logic [mmm_pkg::IDX_W-1:0]     m_last, n_last, p_last;
    logic                          accept;
    logic                          entry_last;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mmm_pkg::DIM_RESET;
            r_inner <= mmm_pkg::DIM_RESET;
            r_cols  <= mmm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mmm_pkg::CFG_ROWS_A:     r_rows  <= i_cfg_data;
                mmm_pkg::CFG_INNER_SIZE: r_inner <= i_cfg_data;
                mmm_pkg::CFG_COLS_B:     r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_last = mmm_pkg::eff_last(r_rows);
    assign n_last = mmm_pkg::eff_last(r_inner);
    assign p_last = mmm_pkg::eff_last(r_cols);

    assign o_req_ready = (r_state == mmm_pkg::ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign entry_last  = (r_i == m_last) && (r_j == p_last);

    // Sequencer: RUN issues one k per cycle, DRAIN waits for the sum, EMIT hands it over
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;

        o_cmd          = '0;
        o_cmd.we_a     = accept && (i_req_func == mmm_pkg::FN_LOAD_A);
        o_cmd.we_b     = accept && (i_req_func == mmm_pkg::FN_LOAD_B);
        o_cmd.rd_i     = r_i;
        o_cmd.rd_j     = r_j;
        o_cmd.rd_k     = r_k;
        o_cmd.first    = (r_k == '0);
        o_cmd.last     = (r_k == n_last);
        o_cmd.out_row  = r_i;
        o_cmd.out_col  = r_j;
        o_cmd.out_last = entry_last;

        case (r_state)
            mmm_pkg::ST_IDLE: begin
                if (accept && (i_req_func == mmm_pkg::FN_COMPUTE)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = mmm_pkg::ST_RUN;
                end
            end
            mmm_pkg::ST_RUN: begin
                o_cmd.rd_en = 1'b1;
                if (r_k == n_last) begin
                    n_state = mmm_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mmm_pkg::ST_DRAIN: begin
                if (i_status.acc_done) begin
                    n_state = mmm_pkg::ST_EMIT;
                end
            end
            mmm_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_k            = '0;
                    if (entry_last) begin
                        n_state = mmm_pkg::ST_IDLE;
                    end else begin
                        n_state = mmm_pkg::ST_RUN;
                        if (r_j == p_last) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = mmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmm_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

/* hdl/matrix_matrix_multiply.sv */
// Matrix multiply block C = A * B (signed Q8.8 operands, Q19.16 sums).
// Top level: depends on mmm_pkg, mmm_if, mmm_ctrl, mmm_datapath and the defines header.
//
// Usage:
//   i_req (valid/ready) carries requests: func 0 stores value as A(row,col),
//   func 1 stores it as B(row,col), func 2 computes C, func 3 is dropped.
//   o_res (valid/ready) returns one result per C entry, row-major, with last
//   set on the final one. Dimensions come from the write port i_cfg_*:
//   index 0 rows_a, 1 inner_size, 2 cols_b (0 acts as 1, above 8 as 8).
// Sequencing:
//   Loads and dropped requests are accepted whenever ready is high, which is while idle.
//   A compute request holds ready low until its last result is in the output
//   register. Each C entry takes one memory read pair per inner step through
//   the shared multiply-accumulate, then the read, multiply and accumulate
//   pipeline stages and a hand-off into the output register.
// Reset (i_rst_n, synchronous, active low) sets all dimensions to 8 and
// idles the sequencer; A and B contents are undefined until loaded.
// A stalled receiver holds the result in the output register; the sequencer
// waits with the next finished sum until that register is free.
`include "matrix_matrix_multiply_defines.svh"

module matrix_matrix_multiply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mmm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmm_pkg::DIM_W-1:0]         i_cfg_data,
    mmm_req_if.sink                           i_req,
    mmm_res_if.source                         o_res
);

    mmm_pkg::t_cmd    cmd;
    mmm_pkg::t_status status;
    logic             req_ready;

    mmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mmm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_wr_row    (i_req.row),
        .i_wr_col    (i_req.col),
        .i_wr_value  (i_req.value),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_row   (o_res.out_row),
        .o_out_col   (o_res.out_col),
        .o_out_sum   (o_res.sum),
        .o_out_last  (o_res.last)
    );

    assign i_req.ready = req_ready;

    // A held result is never overwritten
    `MMM_ASSERT_SAME(a_no_overwrite, cmd.load_out, status.out_free, "output overwritten")
    // No read is issued in the cycle after the final inner step
    `MMM_ASSERT_NEXT(a_issue_stops, cmd.rd_en && cmd.last, !cmd.rd_en, "read after last step")
    // Handing over the final entry returns the block to accepting requests
    `MMM_ASSERT_NEXT(a_idle_after_last, cmd.load_out && cmd.out_last, req_ready,
        "not idle after last entry")

endmodule

/* tb/sv/mmm_product_checker.sv */
// Scoreboard for the matrix multiply block: mirrors the A/B stores and the
// dimension registers, predicts every C entry and checks the result channel.
// Depends on mmm_pkg and the channel interfaces in mmm_if.
module mmm_product_checker
    import mmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    mmm_req_if                   i_req,
    mmm_res_if                   i_res,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count
);

    // One predicted entry of C
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } c_entry_t;

    logic [VAL_W-1:0] a_mirror [DEPTH];
    logic [VAL_W-1:0] b_mirror [DEPTH];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] inner_reg;
    logic [DIM_W-1:0] cols_reg;
    c_entry_t         c_entry_q [$];
    int               fails;
    int               results;

    // Dimension actually used: zero counts as one, anything above the store clamps
    function automatic int dim_used(input logic [DIM_W-1:0] r);
        if (r == '0) return 1;
        if (int'(r) > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    // Queue every entry of C = A * B in row-major order, exact 64-bit sums cut to SUM_W
    task automatic predict_product();
        int       m;
        int       n;
        int       p;
        longint   acc;
        c_entry_t ent;
        m = dim_used(rows_reg);
        n = dim_used(inner_reg);
        p = dim_used(cols_reg);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    acc += longint'($signed(a_mirror[i * MAX_DIM + k]))
                         * longint'($signed(b_mirror[k * MAX_DIM + j]));
                end
                ent.row  = IDX_W'(i);
                ent.col  = IDX_W'(j);
                ent.sum  = acc[SUM_W-1:0];
                ent.last = (i == m - 1) && (j == p - 1);
                c_entry_q.push_back(ent);
            end
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_entry();
        c_entry_t ent;
        results++;
        if (c_entry_q.size() == 0) begin
            fails++;
            $display("%0t: unexpected C entry row %0d col %0d sum %0d", $time,
                     i_res.out_row, i_res.out_col, $signed(i_res.sum));
            return;
        end
        ent = c_entry_q.pop_front();
        if (i_res.out_row !== ent.row) begin
            fails++;
            $display("%0t: out_row expected %0d actual %0d", $time, ent.row, i_res.out_row);
        end
        if (i_res.out_col !== ent.col) begin
            fails++;
            $display("%0t: out_col expected %0d actual %0d", $time, ent.col, i_res.out_col);
        end
        if (i_res.sum !== ent.sum) begin
            fails++;
            $display("%0t: sum of (%0d,%0d) expected %0d actual %0d", $time, ent.row, ent.col,
                     $signed(ent.sum), $signed(i_res.sum));
        end
        if (i_res.last !== ent.last) begin
            fails++;
            $display("%0t: last of (%0d,%0d) expected %0b actual %0b", $time, ent.row, ent.col,
                     ent.last, i_res.last);
        end
    endtask

    // Track register writes and requests, check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg  = DIM_RESET;
            inner_reg = DIM_RESET;
            cols_reg  = DIM_RESET;
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_ROWS_A:     rows_reg  = i_cfg_data;
                    CFG_INNER_SIZE: inner_reg = i_cfg_data;
                    CFG_COLS_B:     cols_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                case (i_req.func)
                    FN_LOAD_A:  a_mirror[{i_req.row, i_req.col}] = i_req.value;
                    FN_LOAD_B:  b_mirror[{i_req.row, i_req.col}] = i_req.value;
                    FN_COMPUTE: predict_product();
                    default: ;
                endcase
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                check_entry();
            end
        end
        o_fail_count   <= fails;
        o_pending      <= c_entry_q.size();
        o_result_count <= results;
    end

endmodule

/* tb/sv/tb_matrix_matrix_multiply.sv */
// Top of the matrix multiply testbench: clock, reset, request and register
// stimulus, result-side stalls and the verdict.
// Depends on mmm_pkg, mmm_if, matrix_matrix_multiply and mmm_product_checker.
module tb_matrix_matrix_multiply;
    import mmm_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int LOAD_ITEMS  = 400;
    localparam int SETTLE      = 20;
    localparam int LONG_HOLD   = 600;
    localparam int CYCLE_LIMIT = 2000000;

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} t_rx_mode;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_data;

    mmm_req_if req_ch ();
    mmm_res_if res_ch ();

    int fail_count;
    int pending;
    int result_count;

    // Stimulus bookkeeping
    bit               a_loaded [DEPTH];
    bit               b_loaded [DEPTH];
    logic [DIM_W-1:0] rows_cur;
    logic [DIM_W-1:0] inner_cur;
    logic [DIM_W-1:0] cols_cur;
    int               burst_left = 0;
    int               reqs_sent = 0;
    int               computes_sent = 0;
    int               settings = 0;
    int               cycles = 0;
    logic             hold_request = 1'b0;

    // Receiver state
    t_rx_mode rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       rx_phase = 0;
    bit       hold_done = 1'b0;
    logic     rdy_next;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    matrix_matrix_multiply dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    mmm_product_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_req          (req_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d C entries still due", cycles, pending);
            $display("tb_matrix_matrix_multiply NOT OK");
            $finish;
        end
    end

    // Result side: changing stall patterns, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            rdy_next = 1'b0;
        end else begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                rdy_next = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:  rdy_next = 1'b1;
                    RX_COIN:  rdy_next = ($urandom_range(0, 1) == 1);
                    RX_THIRD: rdy_next = (rx_phase % 3 == 0);
                    default:  rdy_next = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
        res_ch.ready <= rdy_next;
    end

    function automatic int dim_span(input logic [DIM_W-1:0] r);
        if (r == '0) return 1;
        if (int'(r) > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    // Mostly small dimensions, sometimes zero, full size or clamped
    function automatic logic [DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0) return '0;
        if (sel == 1) return DIM_W'($urandom_range(9, 15));
        if (sel == 2) return DIM_W'(MAX_DIM);
        if (sel == 3) return DIM_W'($urandom_range(5, 7));
        return DIM_W'($urandom_range(1, 4));
    endfunction

    // Operand mix: both extremes, small values and full-range noise
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return VAL_W'($urandom_range(0, 1024) - 512);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Offer one request in sender bursts; returns at the accepting edge
    task automatic send_req(input logic [FUNC_W-1:0] fn, input int r, input int c,
                            input logic [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.func  <= fn;
        req_ch.row   <= IDX_W'(r);
        req_ch.col   <= IDX_W'(c);
        req_ch.value <= v;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (fn == FN_LOAD_A) a_loaded[r * MAX_DIM + c] = 1'b1;
        if (fn == FN_LOAD_B) b_loaded[r * MAX_DIM + c] = 1'b1;
        if (fn != FN_UNUSED) reqs_sent++;
        if (fn == FN_COMPUTE) computes_sent++;
    endtask

    // Dropped code or a load anywhere in the store
    task automatic send_noise();
        logic [FUNC_W-1:0] fn;
        case ($urandom_range(0, 2))
            0:       fn = FN_UNUSED;
            1:       fn = FN_LOAD_A;
            default: fn = FN_LOAD_B;
        endcase
        send_req(fn, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
    endtask

    task automatic send_compute();
        send_req(FN_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), VAL_W'($urandom));
    endtask

    // Drop valid and wait for the block to drain
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] n,
                              input logic [DIM_W-1:0] c);
        rows_cur  = r;
        inner_cur = n;
        cols_cur  = c;
        settings++;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROWS_A;
        cfg_data <= r;
        @(posedge clk);
        cfg_idx  <= CFG_INNER_SIZE;
        cfg_data <= n;
        @(posedge clk);
        cfg_idx  <= CFG_COLS_B;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase: two to five noise requests, or optional new dimensions, shuffled loads and one or two computes
    task automatic run_sequence();
        int kind;
        int m;
        int n;
        int p;
        int cnt;
        int sw;
        int tmp;
        int code;
        int plan [2 * DEPTH];
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(2, 5)) send_noise();
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            wait_idle();
            write_dims(pick_dim(), pick_dim(), pick_dim());
        end
        m = dim_span(rows_cur);
        n = dim_span(inner_cur);
        p = dim_span(cols_cur);
        cnt = 0;
        // full reload, or a partial one that still covers never-written entries
        for (int i = 0; i < m; i++) begin
            for (int k = 0; k < n; k++) begin
                if (kind < 7 || !a_loaded[i * MAX_DIM + k] || $urandom_range(0, 2) == 0) begin
                    plan[cnt] = i * MAX_DIM + k;
                    cnt++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < p; j++) begin
                if (kind < 7 || !b_loaded[k * MAX_DIM + j] || $urandom_range(0, 2) == 0) begin
                    plan[cnt] = DEPTH + k * MAX_DIM + j;
                    cnt++;
                end
            end
        end
        for (int x = cnt - 1; x > 0; x--) begin
            sw       = $urandom_range(0, x);
            tmp      = plan[x];
            plan[x]  = plan[sw];
            plan[sw] = tmp;
        end
        for (int x = 0; x < cnt; x++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            code = plan[x];
            send_req((code >= DEPTH) ? FN_LOAD_B : FN_LOAD_A, (code % DEPTH) / MAX_DIM,
                     code % MAX_DIM, pick_value());
        end
        send_compute();
        if ($urandom_range(0, 5) == 0) send_compute();
    endtask

    // Main stimulus
    initial begin
        int start_count;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_ROWS_A;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FN_LOAD_A;
        req_ch.row   <= '0;
        req_ch.col   <= '0;
        req_ch.value <= '0;
        rows_cur  = DIM_RESET;
        inner_cur = DIM_RESET;
        cols_cur  = DIM_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1x1 products at the operand extremes; a dropped code must not store
        write_dims(4'd1, 4'd1, 4'd1);
        send_req(FN_LOAD_A, 0, 0, 16'h8000);
        send_req(FN_LOAD_B, 0, 0, 16'h8000);
        send_compute();
        send_req(FN_LOAD_A, 0, 0, 16'h7FFF);
        send_compute();
        send_req(FN_UNUSED, 0, 0, 16'h1234);
        send_compute();

        // zero dimensions act as one
        wait_idle();
        write_dims(4'd0, 4'd0, 4'd0);
        send_compute();

        // matrix-vector product, plus a load outside the active dimensions
        wait_idle();
        write_dims(4'd2, 4'd2, 4'd1);
        send_req(FN_LOAD_A, 0, 0, 16'h7FFF);
        send_req(FN_LOAD_A, 0, 1, 16'h7FFF);
        send_req(FN_LOAD_A, 1, 0, 16'h8000);
        send_req(FN_LOAD_A, 1, 1, 16'h0001);
        send_req(FN_LOAD_B, 0, 0, 16'h7FFF);
        send_req(FN_LOAD_B, 1, 0, 16'h7FFF);
        send_req(FN_LOAD_A, 7, 7, 16'h5A5A);
        send_compute();

        start_count = reqs_sent;

        // clamped full size with extreme sums; long result hold while loads queue up
        wait_idle();
        write_dims(4'd15, 4'd15, 4'd15);
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                send_req(FN_LOAD_A, r, c, 16'h8000);
                send_req(FN_LOAD_B, r, c, (c % 2 == 0) ? 16'h8000 : 16'h7FFF);
            end
        end
        hold_request <= 1'b1;
        send_compute();
        for (int c = 0; c < MAX_DIM; c++) send_req(FN_LOAD_A, 0, c, 16'h7FFF);
        send_compute();

        while (reqs_sent - start_count < LOAD_ITEMS) run_sequence();

        wait_idle();
        $display("ran %0d requests with %0d computes over %0d dimension settings",
                 reqs_sent, computes_sent, settings);
        $display("checked %0d C entries, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_matrix_matrix_multiply OK");
        end else begin
            $display("tb_matrix_matrix_multiply NOT OK");
        end
        $finish;
    end

endmodule
